### hdl/uttb_pkg.sv
// Shared types and constants for the UUID text to bytes converter.
// Holds the classified-character format used between front, queue and back.
// No dependencies.
package uttb_pkg;

	// Character codes the front end recognises
	localparam logic [7:0] CHAR_DASH   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_F   = 8'h46;
	localparam logic [7:0] CHAR_LO_A   = 8'h61;
	localparam logic [7:0] CHAR_LO_F   = 8'h66;

	// Letters a..f and A..F carry 1..6 in their low nibble
	localparam logic [3:0] LETTER_BIAS = 4'd9;

	// Hex digits in one complete UUID text
	localparam logic [5:0] UUID_DIGITS = 6'd32;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Result queue depth in the back end
	localparam int OUT_DEPTH = 2;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);

	// Class of one accepted item
	typedef enum logic [1:0] {
		CLS_HEX  = 2'd0,
		CLS_DASH = 2'd1,
		CLS_BAD  = 2'd2,
		CLS_END  = 2'd3
	} cls_t;

	// Status codes reported at end of text
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_TOO_MANY = 2'd2,
		ST_TOO_FEW  = 2'd3
	} status_t;

	// Classified item passed from front to back
	typedef struct packed {
		cls_t       cls;
		logic [3:0] nibble;
	} item_t;

	// One result as presented at the output
	typedef struct packed {
		logic [7:0] byte_value;
		logic [3:0] byte_index;
		logic       is_status;
		status_t    status;
	} result_t;

	// Queue handshake seen by the producer and consumer
	typedef struct packed {
		logic push;
		logic pop;
	} qctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qsts_t;

endpackage

### hdl/uttb_front.sv
// Front end: accepts input transactions and classifies each character.
// Depends on uttb_pkg; feeds uttb_queue.
module uttb_front
	import uttb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] character,
	input  logic       q_full,
	output logic       q_push,
	output item_t      q_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t cls_item;
	logic  take;

	// Classify the incoming character
	always_comb begin
		cls_item.nibble = '0;
		if (kind) begin
			cls_item.cls = CLS_END;
		end else begin
			case (character) inside
				CHAR_DASH: begin
					cls_item.cls = CLS_DASH;
				end
				[CHAR_ZERO:CHAR_NINE]: begin
					cls_item.cls    = CLS_HEX;
					cls_item.nibble = character[3:0];
				end
				[CHAR_UP_A:CHAR_UP_F], [CHAR_LO_A:CHAR_LO_F]: begin
					cls_item.cls    = CLS_HEX;
					cls_item.nibble = character[3:0] + LETTER_BIAS;
				end
				default: begin
					cls_item.cls = CLS_BAD;
				end
			endcase
		end
	end

	// Stall only when the stage is occupied and the queue cannot take it
	assign full   = valid_s1 && q_full;
	assign take   = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	// Hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls_item;
		end
	end

endmodule

### hdl/uttb_queue.sv
// Short queue of classified items between front and back.
// Depends on uttb_pkg.
module uttb_queue
	import uttb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  qctl_t ctl,
	input  item_t push_item,
	output item_t pop_item,
	output qsts_t sts
);

	item_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign sts       = '{full:  (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH)),
	                     empty: (count_q == '0)};
	assign do_push   = ctl.push && !sts.full;
	assign do_pop    = ctl.pop && !sts.empty;
	assign pop_item  = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/uttb_back.sv
// Back end: tracks digit count, pending nibble and first error, and
// queues byte and status results. Depends on uttb_pkg; fed by uttb_queue.
module uttb_back
	import uttb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       q_empty,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] byte_value,
	output logic [3:0] byte_index,
	output logic       is_status,
	output logic [1:0] status
);

	logic [5:0]        digits_q;
	logic [3:0]        high_q;
	status_t           err_q;

	result_t           out_mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0] out_wr_q;
	logic [OUT_AW-1:0] out_rd_q;
	logic [OUT_AW:0]   out_cnt_q;

	logic              out_take;
	logic              out_room;
	logic              emit;
	result_t           res;
	logic [5:0]        digits_nxt;
	logic [3:0]        high_nxt;
	status_t           err_nxt;
	result_t           head;

	assign out_take = pop && !empty;
	assign out_room = (out_cnt_q != (OUT_AW+1)'(OUT_DEPTH)) || out_take;
	assign q_pop    = !q_empty && out_room;

	// Work out the effect of the item at the head of the queue
	always_comb begin
		digits_nxt     = digits_q;
		high_nxt       = high_q;
		err_nxt        = err_q;
		emit           = 1'b0;
		res.byte_value = {high_q, item.nibble};
		res.byte_index = digits_q[4:1];
		res.is_status  = 1'b0;
		res.status     = ST_OK;
		case (item.cls)
			CLS_END: begin
				emit           = 1'b1;
				res.byte_value = '0;
				res.byte_index = '0;
				res.is_status  = 1'b1;
				if (err_q != ST_OK) begin
					res.status = err_q;
				end else if (digits_q != UUID_DIGITS) begin
					res.status = ST_TOO_FEW;
				end else begin
					res.status = ST_OK;
				end
				digits_nxt = '0;
				high_nxt   = '0;
				err_nxt    = ST_OK;
			end
			CLS_DASH: begin
			end
			CLS_BAD: begin
				if (err_q == ST_OK) begin
					err_nxt = ST_BAD_CHAR;
				end
			end
			CLS_HEX: begin
				if (err_q == ST_OK) begin
					if (digits_q >= UUID_DIGITS) begin
						err_nxt = ST_TOO_MANY;
					end else begin
						digits_nxt = digits_q + 1'b1;
						if (!digits_q[0]) begin
							high_nxt = item.nibble;
						end else begin
							emit = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Update the per-text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			high_q   <= '0;
			err_q    <= ST_OK;
		end else if (q_pop) begin
			digits_q <= digits_nxt;
			high_q   <= high_nxt;
			err_q    <= err_nxt;
		end
	end

	// Store results waiting for the consumer
	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (q_pop && emit) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (out_take) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			if ((q_pop && emit) && !out_take) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (!(q_pop && emit) && out_take) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	// Present the oldest result
	assign head       = out_mem_q[out_rd_q];
	assign empty      = (out_cnt_q == '0);
	assign byte_value = head.byte_value;
	assign byte_index = head.byte_index;
	assign is_status  = head.is_status;
	assign status     = head.status;

endmodule

### hdl/uuid_text_to_bytes_core.sv
// UUID text to bytes converter, top level.
// Path: an input passes the front stage register, the item queue and the result queue in turn.
// Throughput: one input transaction per cycle while results are popped; the two-entry
// result queue and the item queue absorb pop low until they fill, then full stalls input.
// Reset: arst_n clears all queues and the per-text state at once; no clear pass.
module uuid_text_to_bytes_core
	import uttb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] character,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] byte_value,
	output logic [3:0] byte_index,
	output logic       is_status,
	output logic [1:0] status
);

	qctl_t q_ctl;
	qsts_t q_sts;
	item_t q_in;
	item_t q_out;
	logic  q_push;
	logic  q_pop;

	// Gather the queue controls from both sides
	assign q_ctl = '{push: q_push, pop: q_pop};

	uttb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.character (character),
		.q_full    (q_sts.full),
		.q_push    (q_push),
		.q_item    (q_in)
	);

	uttb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.push_item (q_in),
		.pop_item  (q_out),
		.sts       (q_sts)
	);

	uttb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_out),
		.q_empty    (q_sts.empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.byte_value (byte_value),
		.byte_index (byte_index),
		.is_status  (is_status),
		.status     (status)
	);

`ifndef NO_ASSERTIONS
	// Front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) !(q_ctl.push && q_sts.full))
		else $error("queue overflow");

	// Back never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) !(q_ctl.pop && q_sts.empty))
		else $error("queue underflow");

	// A byte result always carries a clear status field
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_status) |-> (status == ST_OK))
		else $error("byte result with status set");

	// Input stalls only while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n) full |-> q_sts.full)
		else $error("stall without full queue");
`endif

endmodule

### verif/tb_uuid_text_to_bytes_core.sv
// Self-checking testbench for uuid_text_to_bytes_core: drives UUID text streams
// through the push/full side and checks every byte and status on the pop/empty side.
// Depends on uttb_pkg (character codes, status and result types) and the core RTL.
`timescale 1ns / 1ps

module tb_uuid_text_to_bytes_core
	import uttb_pkg::*;
();

	// No idling once fewer than this many characters remain to be sent
	localparam int QUIET_TAIL  = 120;
	localparam int RANDOM_ITEMS = 600;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} text_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       kind = 1'b0;
	logic [7:0] character = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] byte_value;
	logic [3:0] byte_index;
	logic       is_status;
	logic [1:0] status;

	text_item_t pending_chars[$];
	result_t    due_results[$];

	// Decoder state mirrored from the block
	logic [5:0] digits_taken = '0;
	logic [3:0] pair_high = '0;
	status_t    first_error = ST_OK;

	text_item_t next_char;
	result_t    want;
	int         gap_left = 0;
	int         stall_left = 0;
	int         n_sent = 0;
	int         n_bytes = 0;
	int         n_texts = 0;
	int         n_status[4] = '{0, 0, 0, 0};
	int         n_fail = 0;

	uuid_text_to_bytes_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.character  (character),
		.empty      (empty),
		.pop        (pop),
		.byte_value (byte_value),
		.byte_index (byte_index),
		.is_status  (is_status),
		.status     (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Value of a hex digit, or 16 for any other byte
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE) return 5'(c - CHAR_ZERO);
		if (c >= CHAR_LO_A && c <= CHAR_LO_F) return 5'(c - CHAR_LO_A + 8'd10);
		if (c >= CHAR_UP_A && c <= CHAR_UP_F) return 5'(c - CHAR_UP_A + 8'd10);
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) return CHAR_ZERO + 8'(v);
		return (upper ? CHAR_UP_A : CHAR_LO_A) + 8'(v) - 8'd10;
	endfunction

	// Advance the decoder by one accepted transaction and queue what it yields
	function automatic void decode_char(input logic k, input logic [7:0] c);
		logic [4:0] nib;
		result_t    r;
		r = '0;
		if (k) begin
			r.is_status = 1'b1;
			if (first_error != ST_OK) r.status = first_error;
			else if (digits_taken != UUID_DIGITS) r.status = ST_TOO_FEW;
			else r.status = ST_OK;
			due_results.push_back(r);
			n_status[r.status]++;
			n_texts++;
			digits_taken = '0;
			pair_high = '0;
			first_error = ST_OK;
		end else if (c != CHAR_DASH && first_error == ST_OK) begin
			nib = hex_nibble(c);
			if (nib[4]) begin
				first_error = ST_BAD_CHAR;
			end else if (digits_taken >= UUID_DIGITS) begin
				first_error = ST_TOO_MANY;
			end else if (!digits_taken[0]) begin
				pair_high = nib[3:0];
				digits_taken = digits_taken + 6'd1;
			end else begin
				r.byte_value = {pair_high, nib[3:0]};
				r.byte_index = digits_taken[4:1];
				due_results.push_back(r);
				n_bytes++;
				digits_taken = digits_taken + 6'd1;
			end
		end
	endfunction

	task automatic put(input logic k, input logic [7:0] c);
		pending_chars.push_back('{kind: k, ch: c});
	endtask

	// Queue n random digits, with dashes either at the usual places or scattered,
	// and one invalid byte in front of digit bad_at (none if out of range)
	task automatic put_digits(input int n, input int bad_at, input bit std_dash);
		logic [7:0] junk;
		for (int i = 0; i < n; i++) begin
			if (std_dash ? (i == 8 || i == 12 || i == 16 || i == 20) :
					($urandom_range(0, 9) == 0))
				put(1'b0, CHAR_DASH);
			if (i == bad_at) begin
				do junk = 8'($urandom_range(0, 255));
				while (hex_nibble(junk) != 5'h10 || junk == CHAR_DASH);
				put(1'b0, junk);
			end
			put(1'b0, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
		end
	endtask

	// Driver: hold a transaction until taken, idle in bursts, then send the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			kind <= 1'b0;
			character <= 8'h00;
			gap_left <= 0;
		end else begin
			if (push && !full) begin
				decode_char(kind, character);
				n_sent++;
			end
			if (push && full) begin
				// hold the current transaction
			end else if (gap_left > 0) begin
				push <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_chars.size() > 0) begin
				next_char = pending_chars.pop_front();
				push <= 1'b1;
				kind <= next_char.kind;
				character <= next_char.ch;
				if (pending_chars.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
					gap_left <= $urandom_range(1, 17);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: check each popped result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left <= 0;
		end else begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: byte_value %0h byte_index %0d is_status %0b status %0d",
						byte_value, byte_index, is_status, status);
					n_fail++;
				end else begin
					want = due_results.pop_front();
					if (byte_value !== want.byte_value) begin
						$error("byte_value: expected %0h, got %0h", want.byte_value, byte_value);
						n_fail++;
					end
					if (byte_index !== want.byte_index) begin
						$error("byte_index: expected %0d, got %0d", want.byte_index, byte_index);
						n_fail++;
					end
					if (is_status !== want.is_status) begin
						$error("is_status: expected %0b, got %0b", want.is_status, is_status);
						n_fail++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						n_fail++;
					end
				end
			end
			// Stall in random bursts except near the end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (pending_chars.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				stall_left <= $urandom_range(0, 16);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int         pick;
		int         target;
		logic [7:0] edge_chars[7];
		edge_chars = '{8'h00, CHAR_ZERO - 8'd1, CHAR_NINE + 8'd1, CHAR_UP_A - 8'd1,
			CHAR_UP_F + 8'd1, CHAR_LO_A - 8'd1, CHAR_LO_F + 8'd1};

		// Empty text, then digit extremes of both cases ending in a bad byte
		put(1'b1, 8'h00);
		put(1'b0, CHAR_ZERO);
		put(1'b0, CHAR_NINE);
		put(1'b0, CHAR_LO_A);
		put(1'b0, CHAR_LO_F);
		put(1'b0, CHAR_UP_A);
		put(1'b0, CHAR_UP_F);
		put(1'b0, CHAR_DASH);
		put(1'b0, CHAR_ZERO - 8'd1);
		put(1'b1, 8'hFF);
		// The bottom byte, bytes just outside each digit range, and the top byte
		foreach (edge_chars[i]) begin
			put(1'b0, edge_chars[i]);
			put(1'b1, CHAR_DASH);
		end
		put(1'b0, 8'hFF);
		put(1'b1, CHAR_ZERO);
		// A text of one dash only
		put(1'b0, CHAR_DASH);
		put(1'b1, 8'h00);

		target = pending_chars.size() + RANDOM_ITEMS;
		while (pending_chars.size() < target) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				// well-formed text, sometimes with a trailing dash
				put_digits(32, -1, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 5) == 0) put(1'b0, CHAR_DASH);
			end else if (pick == 6) begin
				// too many digits, sometimes followed by a bad byte
				put_digits(33 + $urandom_range(0, 3), 34, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 2) == 0) put(1'b0, 8'h7E);
			end else if (pick == 7) begin
				put_digits($urandom_range(0, 31), -1, 1'($urandom_range(0, 1)));
			end else if (pick == 8) begin
				// bad byte somewhere (none if it lands past the last digit), then the rest of the text is ignored
				put_digits(32 + $urandom_range(0, 1), $urandom_range(0, 32),
					1'($urandom_range(0, 1)));
			end else begin
				// raw noise over the whole byte range
				repeat ($urandom_range(0, 10)) put(1'b0, 8'($urandom_range(0, 255)));
			end
			put(1'b1, 8'($urandom_range(0, 255)));
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_chars.size() != 0 || push) @(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d transactions over %0d texts; checked %0d bytes and %0d statuses",
			n_sent, n_texts, n_bytes, n_texts);
		$display("Statuses: ok %0d, invalid character %0d, too many %0d, too few %0d",
			n_status[ST_OK], n_status[ST_BAD_CHAR], n_status[ST_TOO_MANY], n_status[ST_TOO_FEW]);
		if (n_fail == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Give up well past the slowest legal run
	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", due_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
